### hw/rtl/escexp_pkg.sv
// ----------------------------------------------------------------------------
// escexp_pkg
// Shared types, character codes and helpers for the escape sequence expander.
// ----------------------------------------------------------------------------
package escexp_pkg;

  localparam int CHAR_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int ACC_W    = 10;
  localparam int MAX_OUT  = 5;
  localparam int OUT_CNT_W = $clog2(MAX_OUT + 1);

  // phase codes
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_SLASH = 3'd1;
  localparam logic [2:0] PH_HEX   = 3'd2;
  localparam logic [2:0] PH_DEC   = 3'd3;
  localparam logic [2:0] PH_OCT   = 3'd4;

  localparam logic [ACC_W-1:0]  VALUE_LIMIT = ACC_W'(255);
  localparam logic [CHAR_W-1:0] BYTE_MAX    = CHAR_W'(16'h00FF);
  localparam logic [CHAR_W-1:0] CH_BSLASH   = 16'h005C;

  // escape letters
  localparam logic [BYTE_W-1:0] L_N     = 8'h6E;
  localparam logic [BYTE_W-1:0] L_R     = 8'h72;
  localparam logic [BYTE_W-1:0] L_T     = 8'h74;
  localparam logic [BYTE_W-1:0] L_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] L_B     = 8'h62;
  localparam logic [BYTE_W-1:0] L_F     = 8'h66;
  localparam logic [BYTE_W-1:0] L_V     = 8'h76;
  localparam logic [BYTE_W-1:0] L_BSL   = 8'h5C;
  localparam logic [BYTE_W-1:0] L_DQ    = 8'h22;
  localparam logic [BYTE_W-1:0] L_SQ    = 8'h27;
  localparam logic [BYTE_W-1:0] L_HEX_L = 8'h78;
  localparam logic [BYTE_W-1:0] L_HEX_U = 8'h58;
  localparam logic [BYTE_W-1:0] L_DEC_L = 8'h64;
  localparam logic [BYTE_W-1:0] L_DEC_U = 8'h44;
  localparam logic [BYTE_W-1:0] L_OCT_L = 8'h6F;
  localparam logic [BYTE_W-1:0] L_OCT_U = 8'h4F;

  // expanded control characters
  localparam logic [BYTE_W-1:0] C_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] C_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] C_TAB = 8'h09;
  localparam logic [BYTE_W-1:0] C_NUL = 8'h00;
  localparam logic [BYTE_W-1:0] C_BS  = 8'h08;
  localparam logic [BYTE_W-1:0] C_FF  = 8'h0C;
  localparam logic [BYTE_W-1:0] C_VT  = 8'h0B;

  typedef struct packed {
    logic [2:0]       phase;
    logic [BYTE_W-1:0] letter;
    logic [1:0]       dcnt;
    logic [ACC_W-1:0] acc;
  } esc_state_t;

  typedef struct packed {
    logic [MAX_OUT-1:0][CHAR_W-1:0] ch;
    logic [OUT_CNT_W-1:0]           n;
  } burst_t;

  typedef struct packed {
    logic              wr_en;
    logic              wr_idx;
    logic [BYTE_W-1:0] wr_data;
  } store_wr_t;

  localparam esc_state_t IDLE_ST = '{phase: PH_IDLE, letter: '0, dcnt: '0, acc: '0};

  function automatic burst_t push(burst_t b, logic [CHAR_W-1:0] c);
    burst_t r;
    r = b;
    if (b.n < OUT_CNT_W'(MAX_OUT)) begin
      r.ch[b.n] = c;
      r.n       = b.n + OUT_CNT_W'(1);
    end
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] widen(logic [BYTE_W-1:0] v);
    return {{(CHAR_W-BYTE_W){1'b0}}, v};
  endfunction

endpackage

### hw/rtl/escexp_step.sv
// ----------------------------------------------------------------------------
// escexp_step
// Next-state and result-burst logic for one input character.
// ----------------------------------------------------------------------------
module escexp_step import escexp_pkg::*; (
  input  esc_state_t        st,
  input  logic [BYTE_W-1:0] store0,
  input  logic [BYTE_W-1:0] store1,
  input  logic [CHAR_W-1:0] c,
  input  logic              last,
  output esc_state_t        nst,
  output store_wr_t         swr,
  output burst_t            burst,
  output logic              end_flag
);

  logic             d_ok;
  logic [3:0]       d_val;
  logic [ACC_W-1:0] acc_new;
  logic [2:0]       cnt_inc;
  logic [2:0]       maxd;
  logic             is_dec;
  logic             is_hexl;
  logic             is_hexu;
  burst_t           b;

  always_comb begin
    is_dec  = (c >= 16'h0030) && (c <= 16'h0039);
    is_hexl = (c >= 16'h0061) && (c <= 16'h0066);
    is_hexu = (c >= 16'h0041) && (c <= 16'h0046);
    d_ok    = 1'b0;
    d_val   = c[3:0];
    case (st.phase)
      PH_OCT: d_ok = (c >= 16'h0030) && (c <= 16'h0037);
      PH_DEC: d_ok = is_dec;
      PH_HEX: begin
        d_ok = is_dec || is_hexl || is_hexu;
        if (!is_dec) d_val = c[3:0] + 4'd9;
      end
      default: d_ok = 1'b0;
    endcase
    case (st.phase)
      PH_HEX:  acc_new = (st.acc << 4) + ACC_W'(d_val);
      PH_DEC:  acc_new = (st.acc << 3) + (st.acc << 1) + ACC_W'(d_val);
      default: acc_new = (st.acc << 3) + ACC_W'(d_val);
    endcase
    maxd    = (st.phase == PH_HEX) ? 3'd2 : 3'd3;
    cnt_inc = {1'b0, st.dcnt} + 3'd1;
  end

  always_comb begin
    nst = st;
    b   = '0;
    swr = '{wr_en: 1'b0, wr_idx: st.dcnt[0], wr_data: c[BYTE_W-1:0]};
    case (st.phase)
      PH_IDLE: begin
        if (c == CH_BSLASH) nst.phase = PH_SLASH;
        else b = push(b, c);
      end
      PH_SLASH: begin
        nst = IDLE_ST;
        if (c > BYTE_MAX) begin
          b = push(b, CH_BSLASH);
          b = push(b, c);
        end else begin
          case (c[BYTE_W-1:0])
            L_N:    b = push(b, widen(C_LF));
            L_R:    b = push(b, widen(C_CR));
            L_T:    b = push(b, widen(C_TAB));
            L_ZERO: b = push(b, widen(C_NUL));
            L_B:    b = push(b, widen(C_BS));
            L_F:    b = push(b, widen(C_FF));
            L_V:    b = push(b, widen(C_VT));
            L_BSL:  b = push(b, CH_BSLASH);
            L_DQ:   b = push(b, widen(L_DQ));
            L_SQ:   b = push(b, widen(L_SQ));
            L_HEX_L, L_HEX_U: begin
              nst.phase  = PH_HEX;
              nst.letter = c[BYTE_W-1:0];
            end
            L_DEC_L, L_DEC_U: begin
              nst.phase  = PH_DEC;
              nst.letter = c[BYTE_W-1:0];
            end
            L_OCT_L, L_OCT_U: begin
              nst.phase  = PH_OCT;
              nst.letter = c[BYTE_W-1:0];
            end
            default: begin
              b = push(b, CH_BSLASH);
              b = push(b, c);
            end
          endcase
        end
      end
      PH_HEX, PH_DEC, PH_OCT: begin
        if (!d_ok) begin
          if (st.dcnt == 2'd0) begin
            b = push(b, CH_BSLASH);
            b = push(b, widen(st.letter));
          end else begin
            b = push(b, widen(st.acc[BYTE_W-1:0]));
          end
          nst = IDLE_ST;
          if (c == CH_BSLASH) nst.phase = PH_SLASH;
          else b = push(b, c);
        end else begin
          swr.wr_en = (st.dcnt < 2'd2);
          nst.acc   = acc_new;
          nst.dcnt  = cnt_inc[1:0];
          if (cnt_inc == maxd) begin
            if ((st.phase != PH_HEX) && (acc_new > VALUE_LIMIT)) begin
              b = push(b, CH_BSLASH);
              b = push(b, widen(st.letter));
              b = push(b, widen(store0));
              b = push(b, widen(store1));
              b = push(b, widen(c[BYTE_W-1:0]));
            end else begin
              b = push(b, widen(acc_new[BYTE_W-1:0]));
            end
            nst = IDLE_ST;
          end
        end
      end
      default: begin
        nst = IDLE_ST;
        if (c == CH_BSLASH) nst.phase = PH_SLASH;
        else b = push(b, c);
      end
    endcase
    if (last) begin
      if (nst.phase == PH_SLASH) begin
        b = push(b, CH_BSLASH);
      end else if (nst.phase != PH_IDLE) begin
        if (nst.dcnt == 2'd0) begin
          b = push(b, CH_BSLASH);
          b = push(b, widen(nst.letter));
        end else begin
          b = push(b, widen(nst.acc[BYTE_W-1:0]));
        end
      end
      nst = IDLE_ST;
    end
    burst    = b;
    end_flag = last && (b.n != '0);
  end

endmodule

### hw/rtl/escape_sequence_expander_core.sv
// ----------------------------------------------------------------------------
// escape_sequence_expander_core
// Backslash escape expander on a stream of 16-bit characters.
// ----------------------------------------------------------------------------
// One character is taken per cycle while in_tready is high. A character that
// expands to k output characters (k up to 5, e.g. a rejected three-digit
// decimal escape) is loaded as a burst into the five-entry output register;
// the burst drains one transfer per cycle while out_tready is high, and
// in_tready stays low until the burst's last transfer is taken, so a new
// character is accepted in the same cycle as that last transfer. The first
// output is registered and appears in the cycle after the input transfer.
module escape_sequence_expander_core import escexp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] char_in
  input  logic        in_tlast,   // string_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] char_out
  output logic        out_tlast   // out_end
);

  esc_state_t                     st_r, st_nxt;
  logic [BYTE_W-1:0]              store_r [0:1];
  store_wr_t                      swr;
  burst_t                         burst;
  logic                           end_flag;
  logic [MAX_OUT-1:0][CHAR_W-1:0] buf_r;
  logic [OUT_CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [OUT_CNT_W-1:0]           idx_r, idx_nxt;
  logic                           last_r;
  logic                           in_fire;
  logic                           out_fire;

  escexp_step u_step (
    .st       (st_r),
    .store0   (store_r[0]),
    .store1   (store_r[1]),
    .c        (in_tdata),
    .last     (in_tlast),
    .nst      (st_nxt),
    .swr      (swr),
    .burst    (burst),
    .end_flag (end_flag)
  );

  assign in_tready  = (cnt_r == '0) || ((cnt_r == OUT_CNT_W'(1)) && out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != '0);
  assign out_fire   = out_tvalid && out_tready;
  assign out_tdata  = buf_r[idx_r];
  assign out_tlast  = last_r && (cnt_r == OUT_CNT_W'(1));

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (in_fire) begin
      cnt_nxt = burst.n;
      idx_nxt = '0;
    end else if (out_fire) begin
      cnt_nxt = cnt_r - OUT_CNT_W'(1);
      idx_nxt = idx_r + OUT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= IDLE_ST;
      cnt_r  <= '0;
      idx_r  <= '0;
      last_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      if (in_fire) begin
        st_r   <= st_nxt;
        last_r <= end_flag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      buf_r <= burst.ch;
      if (swr.wr_en) store_r[swr.wr_idx] <= swr.wr_data;
    end
  end

`ifndef SYNTH
  a_burst_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, idx_r} + {1'b0, cnt_r}) <= (OUT_CNT_W + 1)'(MAX_OUT))
    else $error("output burst index runs past the burst");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r > OUT_CNT_W'(1)) |-> !in_tready)
    else $error("input taken while a burst is still draining");

  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && (cnt_r > OUT_CNT_W'(1))) |=> (out_tvalid && (idx_r == $past(idx_r) + 1'b1)))
    else $error("burst transfer dropped or reordered");

  a_tlast_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tlast |-> (out_tvalid && (cnt_r == OUT_CNT_W'(1))))
    else $error("tlast on a transfer that is not the last of its burst");
`endif

endmodule
